@@ hw/rtl/lca_pkg.sv @@
// Shared types and codes for the lag correlation accumulator.
// Depends on nothing; imported by the datapath, the top level, the checker and the testbench.
package lca_pkg;

  // Item kinds carried on s_tuser
  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_REGION = 3'd1;
  localparam logic [2:0] MODE_SAMPLE = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  // Register indexes on the APB port (byte address / 4)
  localparam logic [1:0] REG_LAG_SPAN     = 2'd0;
  localparam logic [1:0] REG_TRACE_LENGTH = 2'd1;
  localparam logic [1:0] REG_REGION_COUNT = 2'd2;

  // One bin of statistics as stored in the bin RAM
  typedef struct packed {
    logic [47:0] product;
    logic [47:0] square;
    logic [31:0] sum;
    logic [19:0] count;
  } bin_t;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_LOAD_X,
    DP_SQUARE,
    DP_PRODUCT,
    DP_ADD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   bin_live;
  } dp_ctrl_t;

endpackage

@@ hw/rtl/lag_correlation_accumulator_core.sv @@
// Lag correlation accumulator: per-shift count, sum, square sum and product sum.
// Depends on lca_pkg, lca_ram and lca_datapath.
//
// Load, region and clear beats are taken in the idle state. A read beat goes
// through ST_RD_WAIT and ST_RD_OUT (only ST_RD_WAIT for a bin out of range)
// and its result waits in an output register; a read holds in ST_RD_OUT
// while the previous result is still waiting. A current-sample beat walks
// the 2*lag_span bins (lag_span capped at LAG_LIMIT) one after another
// through one shared multiplier and adder; each bin takes a read, a multiply,
// one add step per active region and a write back. A sample past the trace
// end goes back to idle after ST_SQUARE. Bins are cleared at once by valid bits.
module lag_correlation_accumulator_core import lca_pkg::*; #(
  parameter int LAG_LIMIT   = 32,
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_REGIONS = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata: index[11:0], sample_value[27:12], region_start[40:28],
  //          region_end[53:41], zero fill [55:54]
  input  logic [55:0]  s_tdata,
  // s_tuser: mode[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata: shift_value[5:0], pair_count[25:6], sample_sum[57:26],
  //          square_sum[105:58], product_sum[153:106], zero fill [159:154]
  output logic [159:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int NB  = 2 * LAG_LIMIT;
  localparam int BW  = $clog2(NB);
  localparam int BCW = BW + 1;
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int IW  = ((AW > 13) ? AW : 13) + 2;
  localparam int RW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int RCW = $clog2(MAX_REGIONS + 1);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_SQUARE  = 8'b0000_0010,
    ST_BIN_RD  = 8'b0000_0100,
    ST_BIN_MUL = 8'b0000_1000,
    ST_BIN_ACC = 8'b0001_0000,
    ST_BIN_WR  = 8'b0010_0000,
    ST_RD_WAIT = 8'b0100_0000,
    ST_RD_OUT  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [5:0]  lag_span;
  logic [12:0] trace_length;
  logic [2:0]  region_count;
  logic [12:0] region_lower [MAX_REGIONS];
  logic [12:0] region_upper [MAX_REGIONS];

  logic [11:0]    pos;
  logic [BCW-1:0] bin_ix;
  logic [RCW-1:0] reg_ix;
  logic [11:0]    rd_ix;
  logic           rd_hit;
  logic [NB-1:0]  bin_valid;

  // Beat fields
  logic [2:0]  in_mode;
  logic [11:0] in_index;
  logic [15:0] in_sample;
  logic [12:0] in_start;
  logic [12:0] in_end;
  logic        in_fire;
  assign in_mode   = s_tuser;
  assign in_index  = s_tdata[11:0];
  assign in_sample = s_tdata[27:12];
  assign in_start  = s_tdata[40:28];
  assign in_end    = s_tdata[53:41];
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;

  // Effective limits
  logic [BCW-1:0] ms_eff;
  logic [BCW-1:0] nbins;
  logic [RCW-1:0] nreg;
  assign ms_eff = BCW'(({26'd0, lag_span} > 32'(LAG_LIMIT)) ?
                       32'(LAG_LIMIT) : {26'd0, lag_span});
  assign nbins  = BCW'({ms_eff, 1'b0});
  assign nreg   = RCW'(({29'd0, region_count} > 32'(MAX_REGIONS)) ?
                       32'(MAX_REGIONS) : {29'd0, region_count});

  // Reference index for the current bin
  logic [IW-1:0] ref_ix;
  logic          ref_ok;
  logic          reg_match;
  logic          skip;
  assign ref_ix    = IW'(pos) + IW'(ms_eff) - IW'(bin_ix);
  assign ref_ok    = !ref_ix[IW-1] && (32'(ref_ix) < 32'(MAX_SAMPLES));
  assign reg_match = ref_ok && (IW'(region_lower[reg_ix[RW-1:0]]) <= ref_ix) &&
                     (ref_ix < IW'(region_upper[reg_ix[RW-1:0]]));
  assign skip      = ({1'b0, pos} >= trace_length) || (nbins == '0);

  // Reference store
  logic                   ref_we;
  logic [SAMPLE_BITS-1:0] ref_rdata;
  assign ref_we = in_fire && (in_mode == MODE_LOAD) &&
                  (32'(in_index) < 32'(MAX_SAMPLES));

  lca_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (AW'(in_index)),
    .wdata (SAMPLE_BITS'(in_sample)),
    .re    (state == ST_BIN_RD),
    .raddr (ref_ix[AW-1:0]),
    .rdata (ref_rdata)
  );

  // Bin store
  bin_t          bin_rdata;
  bin_t          acc;
  logic          bin_re;
  logic [BW-1:0] bin_raddr;
  logic          bin_live;
  assign bin_re    = (state == ST_BIN_RD) || (in_fire && (in_mode == MODE_READ));
  assign bin_raddr = (state == ST_BIN_RD) ? bin_ix[BW-1:0] : in_index[BW-1:0];
  assign bin_live  = (state == ST_RD_OUT) ? bin_valid[rd_ix[BW-1:0]] :
                                            bin_valid[bin_ix[BW-1:0]];

  lca_ram #(.WIDTH($bits(bin_t)), .DEPTH(NB)) u_bin_ram (
    .clk   (clk),
    .we    (state == ST_BIN_WR),
    .waddr (bin_ix[BW-1:0]),
    .wdata (acc),
    .re    (bin_re),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  // Datapath control
  dp_ctrl_t dp_ctrl;
  always_comb begin
    dp_ctrl.bin_live = bin_live;
    dp_ctrl.op       = DP_HOLD;
    unique case (state)
      ST_IDLE:    if (in_fire && (in_mode == MODE_SAMPLE)) dp_ctrl.op = DP_LOAD_X;
      ST_SQUARE:  dp_ctrl.op = DP_SQUARE;
      ST_BIN_MUL: dp_ctrl.op = DP_PRODUCT;
      ST_BIN_ACC: if (reg_match) dp_ctrl.op = DP_ADD;
      default:    dp_ctrl.op = DP_HOLD;
    endcase
  end

  lca_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
    .clk        (clk),
    .ctrl       (dp_ctrl),
    .sample_raw (in_sample),
    .ref_raw    (ref_rdata),
    .bin_in     (bin_rdata),
    .acc        (acc)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bin_valid <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_mode)
              MODE_SAMPLE: begin
                pos    <= in_index;
                bin_ix <= '0;
                state  <= ST_SQUARE;
              end
              MODE_CLEAR: begin
                bin_valid <= '0;
              end
              MODE_READ: begin
                rd_ix  <= in_index;
                rd_hit <= (13'(in_index) < 13'(nbins));
                state  <= ST_RD_WAIT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SQUARE: begin
          state <= skip ? ST_IDLE : ST_BIN_RD;
        end
        ST_BIN_RD: begin
          state <= ST_BIN_MUL;
        end
        ST_BIN_MUL: begin
          reg_ix <= '0;
          state  <= (nreg == '0) ? ST_BIN_WR : ST_BIN_ACC;
        end
        ST_BIN_ACC: begin
          reg_ix <= reg_ix + RCW'(1);
          if (reg_ix == nreg - RCW'(1)) begin
            state <= ST_BIN_WR;
          end
        end
        ST_BIN_WR: begin
          bin_valid[bin_ix[BW-1:0]] <= 1'b1;
          bin_ix <= bin_ix + BCW'(1);
          state  <= (bin_ix == nbins - BCW'(1)) ? ST_IDLE : ST_BIN_RD;
        end
        ST_RD_WAIT: begin
          state <= rd_hit ? ST_RD_OUT : ST_IDLE;
        end
        ST_RD_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Region table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_REGIONS; r++) begin
        region_lower[r] <= '0;
        region_upper[r] <= '0;
      end
    end else if (in_fire && (in_mode == MODE_REGION) &&
                 (32'(in_index) < 32'(MAX_REGIONS))) begin
      region_lower[RW'(in_index)] <= in_start;
      region_upper[RW'(in_index)] <= in_end;
    end
  end

  // Result register
  logic out_load;
  assign out_load = (state == ST_RD_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[5:0]     <= 6'(13'(rd_ix) - 13'(ms_eff));
      m_tdata[153:6]   <= bin_live ? {bin_rdata.product, bin_rdata.square,
                                      bin_rdata.sum, bin_rdata.count} : '0;
      m_tdata[159:154] <= '0;
    end
  end

  // Configuration registers
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_span     <= 6'd16;
      trace_length <= 13'd4096;
      region_count <= 3'd1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_LAG_SPAN:     lag_span     <= pwdata[5:0];
        REG_TRACE_LENGTH: trace_length <= pwdata[12:0];
        REG_REGION_COUNT: region_count <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LAG_SPAN:     prdata = {26'd0, lag_span};
      REG_TRACE_LENGTH: prdata = {19'd0, trace_length};
      REG_REGION_COUNT: prdata = {29'd0, region_count};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/lca_ram.sv @@
// Generic simple dual-port RAM with registered read.
// No dependencies.
module lca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/lca_datapath.sv @@
// Shared multiplier and bin accumulator of the lag correlation accumulator.
// Depends on lca_pkg.
module lca_datapath import lca_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  dp_ctrl_t               ctrl,
  input  logic [15:0]            sample_raw,
  input  logic [SAMPLE_BITS-1:0] ref_raw,
  input  bin_t                   bin_in,
  output bin_t                   acc
);

  logic signed [SAMPLE_BITS-1:0]   x;
  logic signed [2*SAMPLE_BITS-1:0] mult;
  logic [47:0]                     sq;
  logic [47:0]                     prod;

  // One multiplier: square of the sample, or sample times reference
  assign mult = x * ((ctrl.op == DP_SQUARE) ? x : $signed(ref_raw));

  always_ff @(posedge clk) begin
    case (ctrl.op)
      DP_LOAD_X: begin
        x <= $signed(SAMPLE_BITS'(sample_raw));
      end
      DP_SQUARE: begin
        sq <= 48'(mult);
      end
      DP_PRODUCT: begin
        prod <= 48'(mult);
        acc  <= ctrl.bin_live ? bin_in : '0;
      end
      DP_ADD: begin
        acc.count   <= acc.count + 20'd1;
        acc.sum     <= acc.sum + 32'(x);
        acc.square  <= acc.square + sq;
        acc.product <= acc.product + prod;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/lca_checker.sv @@
// Port-level checks for the lag correlation accumulator, bound to the top level.
// Depends on lca_pkg and lag_correlation_accumulator_core.
module lca_checker import lca_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [2:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [159:0] m_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // A sample beat keeps the block busy for at least the next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == MODE_SAMPLE) |=> !s_tready)
    else $error("ready right after a sample beat");

  // A read beat keeps the block busy while the bin is fetched
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == MODE_READ) |=> !s_tready)
    else $error("ready right after a read beat");

endmodule

bind lag_correlation_accumulator_core lca_checker u_lca_checker (.*);

@@ test/lca_checker.sv @@
// Checker for the lag correlation accumulator: follows APB writes and input beats,
// keeps its own bin statistics and compares every result beat. Depends on lca_pkg.
module lca_scoreboard import lca_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [55:0]  s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           errors,
  output int           pending
);

  localparam int BINS = 64;
  localparam int DEPTH = 4096;
  localparam int REGIONS = 4;
  localparam int SHIFT_CAP = 32;

  // Result fields from the highest bit down
  typedef struct packed {
    logic [47:0] product;
    logic [47:0] square;
    logic [31:0] sum;
    logic [19:0] count;
    logic [5:0]  shift;
  } bin_result_t;

  logic [5:0]         shift_reg;
  logic [12:0]        length_reg;
  logic [2:0]         regions_reg;
  logic signed [15:0] ref_mem [DEPTH];
  logic [12:0]        lower [REGIONS];
  logic [12:0]        upper [REGIONS];
  logic [19:0]        cnt_bin [BINS];
  logic [31:0]        sum_bin [BINS];
  logic [47:0]        sq_bin [BINS];
  logic [47:0]        prod_bin [BINS];
  bin_result_t        bin_reads [$];

  function automatic int eff_shift();
    return (shift_reg > SHIFT_CAP) ? SHIFT_CAP : int'(shift_reg);
  endfunction

  task automatic wipe_bins();
    for (int b = 0; b < BINS; b++) begin
      cnt_bin[b] = '0;
      sum_bin[b] = '0;
      sq_bin[b] = '0;
      prod_bin[b] = '0;
    end
  endtask

  // Add one current sample into every bin whose lagged index falls in a region
  task automatic accumulate(input int pos, input logic signed [15:0] x);
    int ms, nreg, i;
    logic [47:0] sq, prod;
    logic signed [47:0] xw, rw;
    ms = eff_shift();
    nreg = (regions_reg > REGIONS) ? REGIONS : int'(regions_reg);
    xw = 48'(x);
    sq = xw * xw;
    if (pos >= length_reg) return;
    for (int b = 0; b < 2 * ms; b++) begin
      i = pos - (b - ms);
      for (int r = 0; r < nreg; r++) begin
        if (i < 0 || i >= DEPTH) continue;
        if (i < lower[r] || i >= upper[r]) continue;
        rw = 48'(ref_mem[i]);
        prod = xw * rw;
        cnt_bin[b] = cnt_bin[b] + 20'd1;
        sum_bin[b] = sum_bin[b] + 32'(xw);
        sq_bin[b] = sq_bin[b] + sq;
        prod_bin[b] = prod_bin[b] + prod;
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    if (errors < 10)
      $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    bin_result_t got, want;
    int idx, ms;
    if (rst) begin
      shift_reg = 6'd16;
      length_reg = 13'd4096;
      regions_reg = 3'd1;
      for (int r = 0; r < REGIONS; r++) begin
        lower[r] = '0;
        upper[r] = '0;
      end
      wipe_bins();
      bin_reads.delete();
      errors = 0;
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LAG_SPAN:     shift_reg = pwdata[5:0];
          REG_TRACE_LENGTH: length_reg = pwdata[12:0];
          REG_REGION_COUNT: regions_reg = pwdata[2:0];
          default: ;
        endcase
      end
      // Input beats
      if (s_tvalid && s_tready) begin
        idx = int'(s_tdata[11:0]);
        case (s_tuser)
          MODE_LOAD:   ref_mem[idx] = s_tdata[27:12];
          MODE_REGION: if (idx < REGIONS) begin
            lower[idx] = s_tdata[40:28];
            upper[idx] = s_tdata[53:41];
          end
          MODE_SAMPLE: accumulate(idx, s_tdata[27:12]);
          MODE_CLEAR:  wipe_bins();
          MODE_READ: begin
            ms = eff_shift();
            if (idx < 2 * ms) begin
              want.shift = 6'(idx - ms);
              want.count = cnt_bin[idx];
              want.sum = sum_bin[idx];
              want.square = sq_bin[idx];
              want.product = prod_bin[idx];
              bin_reads.push_back(want);
            end
          end
          default: ;
        endcase
      end
      // Result beats
      if (m_tvalid && m_tready) begin
        got = m_tdata[153:0];
        if (bin_reads.size() == 0) begin
          report("unexpected result", '0, 64'(got.count));
        end else begin
          want = bin_reads.pop_front();
          if (got.shift !== want.shift)
            report("shift_value", 64'(want.shift), 64'(got.shift));
          if (got.count !== want.count)
            report("pair_count", 64'(want.count), 64'(got.count));
          if (got.sum !== want.sum)
            report("sample_sum", 64'(want.sum), 64'(got.sum));
          if (got.square !== want.square)
            report("square_sum", 64'(want.square), 64'(got.square));
          if (got.product !== want.product)
            report("product_sum", 64'(want.product), 64'(got.product));
        end
      end
    end
    pending = bin_reads.size();
  end

endmodule

@@ test/tb_top.sv @@
// Top of the lag correlation accumulator testbench: clock, reset, APB setup,
// stream stimulus and verdict. Depends on lca_pkg, lca_scoreboard and the core.
module tb_top import lca_pkg::*;;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           errors, pending;
  int           src_pct = 0, snk_pct = 0;
  int           hold_req = 0, hold_seen = 0, hold_left = 0;
  int           cur_shift = 16;

  always #5 clk = ~clk;

  lag_correlation_accumulator_core DUT (.*);

  lca_scoreboard chk (.*);

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_pct);
    end
  end

  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one beat and hold it until accepted
  task automatic send(input logic [2:0] mode, input logic [11:0] idx,
                      input logic [15:0] value, input logic [12:0] lo, input logic [12:0] hi);
    if ($urandom_range(99) < src_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {2'b00, hi, lo, value, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid, drain expected reads, then let a long sample finish
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic configure(input int ms, input int len, input int nreg,
                           input int src, input int snk);
    settle();
    apb_write(REG_LAG_SPAN, ms);
    apb_write(REG_TRACE_LENGTH, len);
    apb_write(REG_REGION_COUNT, nreg);
    cur_shift = (ms > 32) ? 32 : ms;
    src_pct = src;
    snk_pct = snk;
  endtask

  // Reference indexes in one of the two preloaded windows
  function automatic logic [11:0] window_index();
    return $urandom_range(1) ? 12'($urandom_range(0, 255)) : 12'($urandom_range(3840, 4095));
  endfunction

  task automatic random_beat();
    int pick, lo, hi;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send(MODE_LOAD, window_index(), 16'($urandom), '0, '0);
    end else if (pick < 18) begin
      // Well-formed region inside a window, or an empty/inverted one
      if ($urandom_range(3) == 0) begin
        hi = $urandom_range(0, 8191);
        lo = $urandom_range(hi, 8191);
      end else if ($urandom_range(1)) begin
        lo = $urandom_range(0, 256);
        hi = $urandom_range(lo, 256);
      end else begin
        lo = $urandom_range(3840, 4096);
        hi = $urandom_range(lo, 4096);
      end
      send(MODE_REGION, ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(3)),
           16'($urandom), 13'(lo), 13'(hi));
    end else if (pick < 63) begin
      send(MODE_SAMPLE, ($urandom_range(4) == 0) ? 12'($urandom) : window_index(),
           16'($urandom), 13'($urandom), 13'($urandom));
    end else if (pick < 67) begin
      send(MODE_CLEAR, 12'($urandom), 16'($urandom), 13'($urandom), 13'($urandom));
    end else if (pick < 95) begin
      send(MODE_READ, ($urandom_range(9) == 0 || cur_shift == 0) ? 12'($urandom)
           : 12'($urandom_range(0, 2 * cur_shift - 1)), 16'($urandom), 13'($urandom),
           13'($urandom));
    end else begin
      send(3'($urandom_range(5, 7)), 12'($urandom), 16'($urandom), 13'($urandom),
           13'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Preload both reference windows so no region ever reads an unwritten entry
    for (int i = 0; i < 256; i++) send(MODE_LOAD, 12'(i), 16'($urandom), '0, '0);
    for (int i = 3840; i < 4096; i++) send(MODE_LOAD, 12'(i), 16'($urandom), '0, '0);

    // Directed: extreme regions, extreme samples, edge bins, unused modes
    configure(16, 4096, 4, 0, 0);
    send(MODE_REGION, 0, 0, 13'd0, 13'd256);
    send(MODE_REGION, 1, 0, 13'd3840, 13'd4096);
    send(MODE_REGION, 2, 0, 13'd4095, 13'd4096);
    send(MODE_REGION, 3, 0, 13'd4096, 13'd0);
    send(MODE_REGION, 4095, 0, 13'd8191, 13'd8191);
    send(MODE_SAMPLE, 0, 16'h8000, '0, '0);
    send(MODE_SAMPLE, 4095, 16'h7fff, '0, '0);
    send(MODE_SAMPLE, 10, 16'hffff, '0, '0);
    send(MODE_READ, 0, '0, '0, '0);
    send(MODE_READ, 16, '0, '0, '0);
    send(MODE_READ, 31, '0, '0, '0);
    send(MODE_READ, 32, '0, '0, '0);
    send(MODE_READ, 4095, '0, '0, '0);
    send(3'd5, 0, '0, '0, '0);
    send(3'd6, 0, '0, '0, '0);
    send(3'd7, 0, '0, '0, '0);
    send(MODE_CLEAR, 0, '0, '0, '0);
    send(MODE_READ, 16, '0, '0, '0);

    // Random phases across register settings and idling patterns
    configure(1, 4096, 4, 0, 0);
    repeat (180) random_beat();
    configure(8, 300, 2, 54, 0);
    repeat (220) random_beat();
    configure(32, 4096, 4, 0, 54);
    repeat (200) random_beat();
    // Long receiver hold-off while reads pile up
    hold_req++;
    repeat (30) send(MODE_READ, 12'($urandom_range(0, 63)), '0, '0, '0);
    configure(63, 8191, 7, 35, 35);
    repeat (200) random_beat();
    configure(0, 0, 0, 0, 0);
    repeat (60) random_beat();
    configure(5, 1, 3, 35, 35);
    repeat (200) random_beat();
    configure(12, 4096, 1, 0, 0);
    repeat (180) random_beat();

    settle();
    if (errors == 0) begin
      $display("lag_correlation_accumulator_core: match");
    end else begin
      $display("lag_correlation_accumulator_core: mismatch");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("lag_correlation_accumulator_core: mismatch");
    $finish;
  end

endmodule
